@@ sv/ttmd_pkg.sv @@
`default_nettype none

package ttmd_pkg;

  localparam int unsigned COORD_W = 16;

  typedef logic [COORD_W-1:0] coord_t;

  // configuration register indexes
  localparam logic REG_DEADBAND = 1'b0;

  localparam coord_t DEADBAND_RESET = 16'd10;

endpackage

`default_nettype wire

@@ sv/ttmd_div.sv @@
`default_nettype none

module ttmd_div
  import ttmd_pkg::*;
#(
  parameter int unsigned SUM_W  = 18,
  parameter int unsigned DIV_W  = 2,
  parameter int unsigned D_ALL  = 3,
  parameter int unsigned D_TRIM = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic             trim,
  output logic                  done,
  output coord_t                quotient
);

  // floor(n / d) equals floor(n * ceil(2^SHIFT / d) / 2^SHIFT) while n * (d - 1) < 2^SHIFT,
  // which holds for every sum below 2^SUM_W and every divisor up to 2^DIV_W
  localparam int unsigned SHIFT = SUM_W + DIV_W;
  localparam int unsigned RCP_W = SHIFT + 1;
  localparam int unsigned PRD_W = SUM_W + RCP_W;

  localparam logic [RCP_W-1:0] RCP_ALL =
    RCP_W'(((64'd1 << SHIFT) + 64'(D_ALL) - 64'd1) / 64'(D_ALL));
  localparam logic [RCP_W-1:0] RCP_TRIM =
    RCP_W'(((64'd1 << SHIFT) + 64'(D_TRIM) - 64'd1) / 64'(D_TRIM));

  logic [RCP_W-1:0] rcp;
  logic [PRD_W-1:0] prod;
  logic             done_r;
  coord_t           quo_r;

  assign rcp  = trim ? RCP_TRIM : RCP_ALL;
  assign prod = PRD_W'(dividend) * PRD_W'(rcp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= prod[SHIFT +: COORD_W];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ sv/touch_trimmed_mean_deadband.sv @@
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_pressure, in_sample_x, in_sample_y
// out     | output    | out_valid/out_stall| out_pos_x, out_pos_y, out_pressed
// cfg     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// A release or a sample that does not complete the window is handled in S_IDLE.
// The sample that completes the window starts a scan and a summing pass over
// the stored samples, then uses the shared reciprocal multiplier for x and
// then y, before the deadband update and the output state.
// Synchronous active-low reset clears control, held position and pen flag.
// in_stall is high while a window is being filtered and while a finished
// result cannot leave because out_stall holds it.

module touch_trimmed_mean_deadband
  import ttmd_pkg::*;
#(
  parameter int unsigned WINDOW = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pressure,
  input  wire logic [15:0] in_sample_x,
  input  wire logic [15:0] in_sample_y,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pos_x,
  output logic [15:0]      out_pos_y,
  output logic             out_pressed,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = COORD_W + $clog2(WINDOW);
  localparam int unsigned DIV_W = $clog2(WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIVX = 3'd3;
  localparam logic [2:0] S_DIVY = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_r;
  logic [IDX_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] hi_idx_r;
  logic [IDX_W-1:0] lo_idx_r;
  coord_t           hi_val_r;
  coord_t           lo_val_r;
  logic [SUM_W-1:0] sum_x_r;
  logic [SUM_W-1:0] sum_y_r;
  coord_t           avg_x_r;
  coord_t           avg_y_r;
  coord_t           held_x_r;
  coord_t           held_y_r;
  logic             pen_down_r;
  coord_t           deadband_r;
  logic             go_r;

  coord_t           win_x_r [WINDOW];
  coord_t           win_y_r [WINDOW];

  logic             out_valid_r;
  coord_t           out_pos_x_r;
  coord_t           out_pos_y_r;
  logic             out_pressed_r;

  logic             in_acc;
  logic             release_acc;
  logic             sample_acc;
  logic             window_full;
  logic             out_free;
  logic             cfg_wr;
  coord_t           x_rd;
  coord_t           y_rd;
  logic             keep;
  coord_t           dx;
  coord_t           dy;
  logic             move;

  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic             div_trim;
  logic             div_done;
  coord_t           div_quot;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE) || !out_free;
  assign in_acc      = in_valid && !in_stall;
  assign release_acc = in_acc && (in_pressure == '0);
  assign sample_acc  = in_acc && (in_pressure != '0);
  assign window_full = (count_r == IDX_W'(WINDOW - 1));

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEADBAND) ? {16'd0, deadband_r} : 32'd0;

  assign x_rd = win_x_r[idx_r];
  assign y_rd = win_y_r[idx_r];
  assign keep = (idx_r != hi_idx_r) && (idx_r != lo_idx_r);

  always_comb begin
    dx   = (avg_x_r > held_x_r) ? (avg_x_r - held_x_r) : (held_x_r - avg_x_r);
    dy   = (avg_y_r > held_y_r) ? (avg_y_r - held_y_r) : (held_y_r - avg_y_r);
    move = (dx > deadband_r) || (dy > deadband_r);
  end

  // the shared divider serves x first, then y
  assign div_start    = go_r && ((state_r == S_DIVX) || (state_r == S_DIVY));
  assign div_dividend = (state_r == S_DIVX) ? sum_x_r : sum_y_r;
  assign div_trim     = (hi_idx_r != lo_idx_r);

  ttmd_div #(
    .SUM_W  (SUM_W),
    .DIV_W  (DIV_W),
    .D_ALL  (WINDOW - 1),
    .D_TRIM (WINDOW - 2)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .trim     (div_trim),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RESET;
    end else if (cfg_wr && (paddr[2] == REG_DEADBAND)) begin
      deadband_r <= pwdata[15:0];
    end
  end

  // sample window
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      win_x_r[count_r] <= in_sample_x;
      win_y_r[count_r] <= in_sample_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      hi_idx_r    <= '0;
      lo_idx_r    <= '0;
      go_r        <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      pen_down_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (release_acc) begin
            count_r     <= '0;
            pen_down_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end else if (sample_acc) begin
            if (window_full) begin
              // seed the extremes with the first stored sample
              idx_r    <= IDX_W'(1);
              hi_idx_r <= '0;
              lo_idx_r <= '0;
              state_r  <= S_SCAN;
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (x_rd > hi_val_r) begin
            hi_idx_r <= idx_r;
          end
          if (x_rd < lo_val_r) begin
            lo_idx_r <= idx_r;
          end
          if (idx_r == IDX_W'(WINDOW - 1)) begin
            idx_r   <= '0;
            state_r <= S_SUM;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SUM: begin
          if (idx_r == IDX_W'(WINDOW - 1)) begin
            go_r    <= 1'b1;
            state_r <= S_DIVX;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DIVX: begin
          go_r <= 1'b0;
          if (div_done) begin
            go_r    <= 1'b1;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          go_r <= 1'b0;
          if (div_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (move) begin
            held_x_r <= avg_x_r;
            held_y_r <= avg_y_r;
          end
          pen_down_r <= 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            count_r     <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      hi_val_r <= win_x_r[0];
      lo_val_r <= win_x_r[0];
      sum_x_r  <= '0;
      sum_y_r  <= '0;
    end else if (state_r == S_SCAN) begin
      if (x_rd > hi_val_r) begin
        hi_val_r <= x_rd;
      end
      if (x_rd < lo_val_r) begin
        lo_val_r <= x_rd;
      end
    end else if (state_r == S_SUM) begin
      if (keep) begin
        sum_x_r <= sum_x_r + SUM_W'(x_rd);
        sum_y_r <= sum_y_r + SUM_W'(y_rd);
      end
    end
    if ((state_r == S_DIVX) && div_done) begin
      avg_x_r <= div_quot;
    end
    if ((state_r == S_DIVY) && div_done) begin
      avg_y_r <= div_quot;
    end
  end

  // output transaction payload
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && release_acc) begin
      out_pos_x_r   <= held_x_r;
      out_pos_y_r   <= held_y_r;
      out_pressed_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_pos_x_r   <= held_x_r;
      out_pos_y_r   <= held_y_r;
      out_pressed_r <= pen_down_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_pressed = out_pressed_r;

endmodule

`default_nettype wire
